### rtl/core/repeated_beep_sequencer_unit_macros.svh
// ---------------------------------------------------------------------------
// Repeated beep sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef REPEATED_BEEP_SEQUENCER_UNIT_MACROS_SVH
`define REPEATED_BEEP_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define RBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rbs_pkg.sv
// ---------------------------------------------------------------------------
// Repeated beep sequencer package
// Transaction types, opcodes, phase codes and fixed constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbs_pkg;

    localparam logic [1:0] OP_START     = 2'd0;
    localparam logic [1:0] OP_MS_TICK   = 2'd1;
    localparam logic [1:0] OP_TONE_TICK = 2'd2;

    localparam logic [14:0] FREQ_MIN_HZ = 15'd100;
    localparam logic [14:0] FREQ_MAX_HZ = 15'd20000;

    // ceil(2^38 / 1000): x / 1000 == (x * RECIP_1000) >> 38 for x < 2^32
    localparam logic [28:0] RECIP_1000  = 29'd274877907;
    localparam int          RECIP_SHIFT = 38;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SOUND = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] req_freq;
        logic [15:0] req_len;
        logic [15:0] pause_ms;
        logic [7:0]  repeat_count;
    } cmd_t;

    typedef struct packed {
        logic        tone_on;
        logic [14:0] tone_frequency;
        logic [1:0]  phase;
        logic        start_accepted;
        logic        start_pending;
    } status_t;

endpackage

### rtl/core/repeated_beep_sequencer_unit.sv
// ---------------------------------------------------------------------------
// Repeated beep sequencer
// Start / 1 ms tick / tone tick events drive an idle-sound-pause sequencer.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  cmd       in         cmd_valid / cmd_stall       rbs_pkg::cmd_t
//  status    out        status_valid / status_stall rbs_pkg::status_t
//
//  One transaction per clock while status_stall is low; each passes the input
//  register, then the result register.
//  Clamped length * frequency is formed ahead of the input register; the
//  divide by 1000 and the state update sit before the result register.
//  Reset clears the sequencer to idle with one repeat left.
//  A stalled result holds; cmd_stall rises only when both registers are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module repeated_beep_sequencer_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  rbs_pkg::cmd_t    cmd,
    output logic             status_valid,
    input  logic             status_stall,
    output rbs_pkg::status_t status
);
    import rbs_pkg::*;

    logic        in_accept;
    logic        adv;
    logic [14:0] freq_clamp;
    logic [15:0] len_eff;
    logic [30:0] prod;

    logic        s1_valid_reg;
    cmd_t        s1_cmd_reg;
    logic [14:0] s1_freq_reg;
    logic [30:0] s1_prod_reg;

    logic [59:0] quot_full;
    logic [21:0] quot;
    logic [15:0] ticks;
    logic [15:0] pause_eff;

    phase_t      phase_reg, phase_next;
    logic        pending_reg, pending_next;
    logic        running_reg, running_next;
    logic [14:0] freq_reg, freq_next;
    logic [15:0] ticks_per_beep_reg, ticks_per_beep_next;
    logic [15:0] tone_left_reg, tone_left_next;
    logic [15:0] pause_length_reg, pause_length_next;
    logic [15:0] pause_left_reg, pause_left_next;
    logic [7:0]  repeats_left_reg, repeats_left_next;
    logic [7:0]  rep_dec;
    logic [15:0] pause_dec;
    logic [15:0] tone_dec;
    logic        accepted;

    logic        status_valid_reg;
    status_t     status_reg, status_next;

    assign adv       = s1_valid_reg && (!status_valid_reg || !status_stall);
    assign cmd_stall = s1_valid_reg && !adv;
    assign in_accept = cmd_valid && !cmd_stall;

    assign freq_clamp = (cmd.req_freq < 16'(FREQ_MIN_HZ)) ? FREQ_MIN_HZ :
                        (cmd.req_freq > 16'(FREQ_MAX_HZ)) ? FREQ_MAX_HZ :
                        cmd.req_freq[14:0];
    assign len_eff    = (cmd.req_len == 16'd0) ? 16'd1 : cmd.req_len;
    assign prod       = 31'(len_eff) * 31'(freq_clamp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg  <= cmd;
            s1_freq_reg <= freq_clamp;
            s1_prod_reg <= prod;
        end
    end

    assign quot_full = 60'(s1_prod_reg) * 60'(RECIP_1000);
    assign quot      = quot_full[59:RECIP_SHIFT];
    assign ticks     = (quot == 22'd0)      ? 16'd1 :
                       (quot > 22'd65535)   ? 16'hFFFF :
                       quot[15:0];
    assign pause_eff = (s1_cmd_reg.pause_ms == 16'd0) ? 16'd1 : s1_cmd_reg.pause_ms;

    assign rep_dec   = repeats_left_reg - 8'(repeats_left_reg != 8'd0);
    assign pause_dec = pause_left_reg - 16'(pause_left_reg != 16'd0);
    assign tone_dec  = tone_left_reg - 16'(tone_left_reg != 16'd0);

    always_comb
    begin
        phase_next          = phase_reg;
        pending_next        = pending_reg;
        running_next        = running_reg;
        freq_next           = freq_reg;
        ticks_per_beep_next = ticks_per_beep_reg;
        tone_left_next      = tone_left_reg;
        pause_length_next   = pause_length_reg;
        pause_left_next     = pause_left_reg;
        repeats_left_next   = repeats_left_reg;
        accepted            = 1'b0;
        if (adv)
        begin
            case (s1_cmd_reg.opcode)
                OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        freq_next           = s1_freq_reg;
                        pause_length_next   = pause_eff;
                        pause_left_next     = pause_eff;
                        ticks_per_beep_next = ticks;
                        tone_left_next      = ticks;
                        if (s1_cmd_reg.repeat_count != 8'd0)
                        begin
                            repeats_left_next = s1_cmd_reg.repeat_count;
                            pending_next      = 1'b1;
                            running_next      = 1'b1;
                            accepted          = 1'b1;
                        end
                    end
                end
                OP_MS_TICK:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (pending_reg)
                            begin
                                phase_next   = PH_SOUND;
                                pending_next = 1'b0;
                            end
                        end
                        PH_SOUND:
                        begin
                            if (tone_left_reg == 16'd0)
                            begin
                                repeats_left_next = rep_dec;
                                phase_next = (rep_dec == 8'd0) ? PH_IDLE : PH_PAUSE;
                            end
                        end
                        PH_PAUSE:
                        begin
                            pause_left_next = pause_dec;
                            if (pause_dec == 16'd0)
                            begin
                                tone_left_next  = ticks_per_beep_reg;
                                pause_left_next = pause_length_reg;
                                running_next    = 1'b1;
                                phase_next      = PH_SOUND;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                OP_TONE_TICK:
                begin
                    if (running_reg)
                    begin
                        tone_left_next = tone_dec;
                        if (tone_dec == 16'd0)
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        status_next.tone_on        = running_next;
        status_next.tone_frequency = freq_next;
        status_next.phase          = phase_next;
        status_next.start_accepted = accepted;
        status_next.start_pending  = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            pending_reg        <= 1'b0;
            running_reg        <= 1'b0;
            freq_reg           <= '0;
            ticks_per_beep_reg <= '0;
            tone_left_reg      <= '0;
            pause_length_reg   <= '0;
            pause_left_reg     <= '0;
            repeats_left_reg   <= 8'd1;
            status_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            pending_reg        <= pending_next;
            running_reg        <= running_next;
            freq_reg           <= freq_next;
            ticks_per_beep_reg <= ticks_per_beep_next;
            tone_left_reg      <= tone_left_next;
            pause_length_reg   <= pause_length_next;
            pause_left_reg     <= pause_left_next;
            repeats_left_reg   <= repeats_left_next;
            if (adv)
            begin
                status_valid_reg <= 1'b1;
            end
            else if (!status_stall)
            begin
                status_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
        end
    end

    assign status_valid = status_valid_reg;
    assign status       = status_reg;

endmodule

### rtl/core/rbs_checker.sv
// ---------------------------------------------------------------------------
// Repeated beep sequencer checker
// Port-level assertions, bound to repeated_beep_sequencer_unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "repeated_beep_sequencer_unit_macros.svh"

module rbs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_stall,
    input rbs_pkg::status_t status,
    input logic             status_valid,
    input logic             status_stall
);
    import rbs_pkg::*;

    `RBS_ASSERT_NEXT(a_status_hold, status_valid && status_stall, status_valid && $stable(status), "stalled status transaction changed")
    `RBS_ASSERT_NOW(a_stall_cause, cmd_stall, status_valid && status_stall, "command stalled while status not held")
    `RBS_ASSERT_NOW(a_accept_pending, status_valid && status.start_accepted, status.start_pending && status.tone_on, "accepted start not pending with tone on")
    `RBS_ASSERT_NOW(a_pending_idle, status_valid && status.start_pending, status.phase == PH_IDLE, "start pending outside idle")
    `RBS_ASSERT_NOW(a_freq_range, status_valid, status.tone_frequency <= FREQ_MAX_HZ, "tone frequency above clamp limit")

endmodule

bind repeated_beep_sequencer_unit rbs_checker u_rbs_checker (.*);
